// ===== hw/rtl/lctma_pkg.sv =====
// Shared widths, defaults and types for the load cell tare moving average block.
package lctma_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned WEIGHT_W = 25;
  localparam int unsigned SUM_W = 32;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 32;

  localparam int unsigned TARE_SAMPLES_DEF = 16;
  localparam int unsigned WINDOW_LENGTH_DEF = 8;

  // Per-stage load enables of the constant divider pipeline.
  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } div_en_t;

endpackage

// ===== hw/rtl/load_cell_tare_moving_average_core.sv =====
// Top level of the load cell tare and boxcar moving average block.
//
// Samples enter on the s_axis channel: tdata carries one 24-bit converter
// word, read as two's complement. Results leave on the m_axis channel: tdata
// carries the 25-bit signed weight, tuser the calibrating flag.
// The first TARE_SAMPLES samples build the tare sum; each answers weight 0
// with calibrating set. Every later sample enters a WINDOW_LENGTH deep
// history and answers the window average minus the tare offset; until the
// history fills, unwritten entries count as zero.
// The result is registered in the window stage, then in a three-stage
// reciprocal divider, then in the output stage before it is valid.
// Throughput: one sample per cycle unless the receiver stalls; the running
// window sum and the pipelined 32x33 multiplier in each divider set that
// figure. Reset clears the tare state, the history and the pipeline; no
// results are pending afterwards. When the receiver stalls, each pipeline
// stage holds its item and empty stages still fill, so s_axis_tready stays
// high until every stage holds an item.
module load_cell_tare_moving_average_core #(
  parameter int unsigned TARE_SAMPLES = lctma_pkg::TARE_SAMPLES_DEF,
  parameter int unsigned WINDOW_LENGTH = lctma_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lctma_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [23:0] raw_sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lctma_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [24:0] weight_value
  output logic                                m_axis_tuser   // [0] calibrating
);
  import lctma_pkg::*;

  logic                    s_transfer;
  logic                    cal;
  logic signed [SUM_W-1:0] sum_d;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] win_quot;
  logic signed [SUM_W-1:0] offset;
  logic signed [SUM_W-1:0] diff;

  logic                    v1_q, va_q, vb_q, vc_q, vo_q;
  logic                    cal1_q, cala_q, calb_q, calc_q, calo_q;
  logic signed [SUM_W-1:0] sum1_q;
  logic [WEIGHT_W-1:0]     weight_q, weight_d;
  logic                    load_1, load_a, load_b, load_c, load_o;
  div_en_t                 win_en;
  div_en_t                 off_en;

  // A stage loads when it is empty or its item moves on.
  assign load_o = !vo_q || m_axis_tready;
  assign load_c = !vc_q || load_o;
  assign load_b = !vb_q || load_c;
  assign load_a = !va_q || load_b;
  assign load_1 = !v1_q || load_a;

  assign s_axis_tready = load_1;
  assign s_transfer    = s_axis_tvalid && load_1;

  assign win_en = '{a: load_a, b: load_b, c: load_c};
  assign off_en = '{a: 1'b1, b: 1'b1, c: 1'b1};

  lctma_window #(
    .TARE_SAMPLES (TARE_SAMPLES),
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .transfer_i(s_transfer),
    .sample_i  (s_axis_tdata[SAMPLE_W-1:0]),
    .cal_o     (cal),
    .sum_d_o   (sum_d),
    .acc_o     (acc)
  );

  lctma_cdiv #(
    .DIVISOR(WINDOW_LENGTH)
  ) u_win_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (win_en),
    .value_i(sum1_q),
    .quot_o (win_quot)
  );

  // The accumulator is frozen once tare ends, so the offset settles
  // before the first window item reaches the output stage.
  lctma_cdiv #(
    .DIVISOR(TARE_SAMPLES)
  ) u_off_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (off_en),
    .value_i(acc),
    .quot_o (offset)
  );

  assign diff     = win_quot - offset;
  assign weight_d = calc_q ? '0 : diff[WEIGHT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      vo_q   <= 1'b0;
      cal1_q <= 1'b0;
      cala_q <= 1'b0;
      calb_q <= 1'b0;
      calc_q <= 1'b0;
      calo_q <= 1'b0;
    end else begin
      if (load_1) begin
        v1_q   <= s_transfer;
        cal1_q <= cal;
      end
      if (load_a) begin
        va_q   <= v1_q;
        cala_q <= cal1_q;
      end
      if (load_b) begin
        vb_q   <= va_q;
        calb_q <= cala_q;
      end
      if (load_c) begin
        vc_q   <= vb_q;
        calc_q <= calb_q;
      end
      if (load_o) begin
        vo_q   <= vc_q;
        calo_q <= calc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_1) begin
      sum1_q <= sum_d;
    end
    if (load_o) begin
      weight_q <= weight_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = M_TDATA_W'(weight_q);
  assign m_axis_tuser  = calo_q;

endmodule

// ===== hw/rtl/lctma_window.sv =====
// Tare accumulation, sample history shift line and running window sum.
module lctma_window #(
  parameter int unsigned TARE_SAMPLES = lctma_pkg::TARE_SAMPLES_DEF,
  parameter int unsigned WINDOW_LENGTH = lctma_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 transfer_i,
  input  logic        [lctma_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 cal_o,
  output logic signed [lctma_pkg::SUM_W-1:0]    sum_d_o,
  output logic signed [lctma_pkg::SUM_W-1:0]    acc_o
);
  import lctma_pkg::*;

  localparam int unsigned CNT_W = $clog2(TARE_SAMPLES + 1);
  localparam logic [CNT_W-1:0] TARE_END = CNT_W'(TARE_SAMPLES);

  logic        [CNT_W-1:0]    count_q, count_d;
  logic signed [SUM_W-1:0]    acc_q, acc_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] win_q [WINDOW_LENGTH];
  logic signed [SUM_W-1:0]    sample_ext;
  logic signed [SUM_W-1:0]    oldest_ext;
  logic                       cal;
  logic                       tare_load;
  logic                       win_load;

  assign sample_ext = SUM_W'($signed(sample_i));
  assign oldest_ext = SUM_W'(win_q[WINDOW_LENGTH-1]);
  assign cal        = (count_q != TARE_END);
  assign tare_load  = transfer_i && cal;
  assign win_load   = transfer_i && !cal;

  always_comb begin
    count_d = count_q;
    acc_d   = acc_q;
    if (tare_load) begin
      count_d = count_q + CNT_W'(1);
      acc_d   = acc_q + sample_ext;
    end
  end

  // Drop the sample that leaves the window and add the new one.
  assign sum_d = sum_q - oldest_ext + sample_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      acc_q   <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      acc_q   <= acc_d;
      if (win_load) begin
        sum_q <= sum_d;
      end
    end
  end

  // Oldest sample sits at the far end of the shift line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_q[i] <= '0;
      end
    end else if (win_load) begin
      win_q[0] <= $signed(sample_i);
      for (int i = 1; i < WINDOW_LENGTH; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  assign cal_o   = cal;
  assign sum_d_o = sum_d;
  assign acc_o   = acc_q;

`ifndef NO_ASSERTIONS
  a_tare_stays_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cal |=> !cal)
    else $error("tare restarted after completion");
  a_tare_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tare_load |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("tare count did not advance on a tare transfer");
  a_sum_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_load |=> $stable(sum_q))
    else $error("window sum changed without a window transfer");
  a_acc_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cal |=> $stable(acc_q))
    else $error("tare accumulator changed after tare");
`endif

endmodule

// ===== hw/rtl/lctma_cdiv.sv =====
// Three-stage signed divide by a constant, truncating toward zero, via reciprocal multiply.
module lctma_cdiv #(
  parameter int unsigned DIVISOR = lctma_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lctma_pkg::div_en_t                 en_i,
  input  logic signed [lctma_pkg::SUM_W-1:0] value_i,
  output logic signed [lctma_pkg::SUM_W-1:0] quot_o
);
  import lctma_pkg::*;

  // Magnitude stays below 2^32, so a SUM_W+1 bit reciprocal gives exact floor quotients.
  localparam int unsigned SHIFT   = SUM_W + $clog2(DIVISOR);
  localparam int unsigned CALC_W  = SHIFT + 1;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [CALC_W-1:0] MULT_FULL =
    ((CALC_W'(1) << SHIFT) + CALC_W'(DIVISOR) - CALC_W'(1)) / CALC_W'(DIVISOR);
  localparam logic [RECIP_W-1:0] MULT = MULT_FULL[RECIP_W-1:0];

  logic        [SUM_W-1:0]  mag_q, mag_d;
  logic                     neg_a_q, neg_b_q;
  logic        [PROD_W-1:0] prod_q, prod_d;
  logic        [SUM_W-1:0]  floor_q;
  logic signed [SUM_W-1:0]  quot_q, quot_d;

  assign mag_d   = value_i[SUM_W-1] ? SUM_W'(-value_i) : SUM_W'(value_i);
  assign prod_d  = PROD_W'(mag_q) * PROD_W'(MULT);
  assign floor_q = SUM_W'(prod_q >> SHIFT);
  assign quot_d  = neg_b_q ? -$signed(floor_q) : $signed(floor_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_a_q <= 1'b0;
      neg_b_q <= 1'b0;
    end else begin
      if (en_i.a) begin
        neg_a_q <= value_i[SUM_W-1];
      end
      if (en_i.b) begin
        neg_b_q <= neg_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      mag_q <= mag_d;
    end
    if (en_i.b) begin
      prod_q <= prod_d;
    end
    if (en_i.c) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule
